>>> rtl/barometric_sensor_compensation_assert.svh
// ----------------------------------------------------------------------------
// barometric sensor compensation assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_ASSERT_SVH

// checked only outside reset
`define BSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define BSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// types and constants shared by the compensation pipeline
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int unsigned DivStages = 64;
  localparam int unsigned TOffset   = 128000;
  localparam int unsigned PBase     = 1048576;
  localparam int unsigned PScale    = 3125;

  typedef enum logic [1:0] {
    BSC_REG_TEMP = 2'd0,
    BSC_REG_PA   = 2'd1,
    BSC_REG_PB   = 2'd2,
    BSC_REG_PC   = 2'd3
  } bsc_reg_e;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } bsc_coef_t;

  typedef struct packed {
    logic        neg;
    logic        inv;
    logic [63:0] nq;
    logic [30:0] rem;
    logic [30:0] md;
    logic [31:0] fine;
  } bsc_div_t;

  typedef struct packed {
    logic        inv;
    logic [63:0] q;
    logic [31:0] fine;
  } bsc_quo_t;

endpackage

>>> rtl/bsc_if.sv
// ----------------------------------------------------------------------------
// bsc channel interfaces
// sample, result and configuration channels with valid and ready
// ----------------------------------------------------------------------------
interface bsc_sample_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source(output valid, raw_temperature, raw_pressure, input ready);
  modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bsc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centidegrees;
  logic signed [31:0] fine_temperature;
  logic        [31:0] pressure_q24_8;
  logic               pressure_invalid;
  modport source(output valid, temperature_centidegrees, fine_temperature,
                 pressure_q24_8, pressure_invalid, input ready);
  modport sink(input valid, temperature_centidegrees, fine_temperature,
               pressure_q24_8, pressure_invalid, output ready);
endinterface

interface bsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front
// temperature and pressure pre-division stages, ten registers deep
// ----------------------------------------------------------------------------
module bsc_front
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [19:0] raw_t_i,
  input  logic [19:0] raw_p_i,
  input  bsc_coef_t   coef_i,
  output logic        valid_o,
  output bsc_div_t    div_o
);

  logic [9:0] vld_q;

  logic [31:0] a1_d, a1_q, b1_d, b1_q, am_d, am_q, bb_d, bb_q;
  logic [31:0] ta_d, ta_q, bm_d, bm_q, fine_d, fine4_q;
  logic [31:0] fine5_q, fine6_q, fine7_q, fine8_q, fine9_q;
  logic [19:0] ap1_q, ap2_q, ap3_q, ap4_q, ap5_q, ap6_q, ap7_q;
  logic signed [32:0] xs;
  logic signed [63:0] xx_d, xx_q, xp5_d, xp5_q, xp2_d, xp2_q;
  logic signed [63:0] y6_d, y6_q, x3_d, x3_q, xp5b_q, xp2b_q;
  logic signed [63:0] y7_d, y7_q, t7_d, t7_q, dm_d, dm_q, diff_d, diff_q;
  logic signed [63:0] num_d, num_q, den_d, den_q;
  logic [20:0] pp;
  bsc_div_t div_d, div_q;

  always_comb begin
    a1_d   = {15'd0, raw_t_i[19:3]} - {15'd0, coef_i.t1, 1'b0};
    b1_d   = {16'd0, raw_t_i[19:4]} - {16'd0, coef_i.t1};
    am_d   = a1_q * {{16{coef_i.t2[15]}}, coef_i.t2};
    bb_d   = b1_q * b1_q;
    ta_d   = 32'($signed(am_q) >>> 11);
    bm_d   = 32'($signed(bb_q) >>> 12) * {{16{coef_i.t3[15]}}, coef_i.t3};
    fine_d = ta_q + 32'($signed(bm_q) >>> 14);
    xs     = $signed({fine4_q[31], fine4_q}) - $signed(33'(TOffset));
    xx_d   = 64'(xs) * 64'(xs);
    xp5_d  = 64'(xs) * 64'($signed(coef_i.p5));
    xp2_d  = 64'(xs) * 64'($signed(coef_i.p2));
    y6_d   = xx_q * 64'($signed(coef_i.p6));
    x3_d   = xx_q * 64'($signed(coef_i.p3));
    y7_d   = y6_q + (xp5b_q <<< 17) + (64'($signed(coef_i.p4)) <<< 35);
    t7_d   = $signed(64'h0000_8000_0000_0000) + (x3_q >>> 8) + (xp2b_q <<< 12);
    dm_d   = t7_q * $signed({48'd0, coef_i.p1});
    pp     = 21'(PBase) - {1'b0, ap7_q};
    diff_d = $signed({12'd0, pp, 31'd0}) - y7_q;
    num_d  = diff_q * $signed(64'(PScale));
    den_d  = dm_q >>> 33;
    div_d.neg  = num_q[63] ^ den_q[63];
    div_d.inv  = (den_q == 64'sd0);
    div_d.nq   = num_q[63] ? 64'(-num_q) : 64'(num_q);
    div_d.rem  = '0;
    div_d.md   = den_q[63] ? 31'(-den_q) : den_q[30:0];
    div_d.fine = fine9_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[8:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q    <= a1_d;    b1_q   <= b1_d;   ap1_q  <= raw_p_i;
      am_q    <= am_d;    bb_q   <= bb_d;   ap2_q  <= ap1_q;
      ta_q    <= ta_d;    bm_q   <= bm_d;   ap3_q  <= ap2_q;
      fine4_q <= fine_d;  ap4_q  <= ap3_q;
      fine5_q <= fine4_q; xx_q   <= xx_d;   xp5_q  <= xp5_d;
      xp2_q   <= xp2_d;   ap5_q  <= ap4_q;
      fine6_q <= fine5_q; y6_q   <= y6_d;   x3_q   <= x3_d;
      xp5b_q  <= xp5_q;   xp2b_q <= xp2_q;  ap6_q  <= ap5_q;
      fine7_q <= fine6_q; y7_q   <= y7_d;   t7_q   <= t7_d;   ap7_q <= ap6_q;
      fine8_q <= fine7_q; dm_q   <= dm_d;   diff_q <= diff_d;
      fine9_q <= fine8_q; num_q  <= num_d;  den_q  <= den_d;
      div_q   <= div_d;
    end
  end

  assign valid_o = vld_q[9];
  assign div_o   = div_q;

endmodule

>>> rtl/bsc_div.sv
// ----------------------------------------------------------------------------
// bsc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bsc_div
  import bsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  bsc_div_t div_i,
  output logic     valid_o,
  output bsc_quo_t quo_o
);

  bsc_div_t st_q [DivStages];
  logic [DivStages-1:0] vld_q;
  bsc_div_t last;

  for (genvar g = 0; g < DivStages; g++) begin : g_stage
    bsc_div_t    src;
    bsc_div_t    nxt;
    logic [31:0] r2;
    if (g == 0) begin : g_first
      assign src = div_i;
    end else begin : g_next
      assign src = st_q[g-1];
    end
    always_comb begin
      nxt = src;
      r2  = {src.rem, src.nq[63]};
      if (r2 >= {1'b0, src.md}) begin
        nxt.rem = 31'(r2 - {1'b0, src.md});
        nxt.nq  = {src.nq[62:0], 1'b1};
      end else begin
        nxt.rem = r2[30:0];
        nxt.nq  = {src.nq[62:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DivStages-2:0], valid_i};
    end
  end

  assign last       = st_q[DivStages-1];
  assign valid_o    = vld_q[DivStages-1];
  assign quo_o.inv  = last.inv;
  assign quo_o.q    = last.neg ? (64'd0 - last.nq) : last.nq;
  assign quo_o.fine = last.fine;

endmodule

>>> rtl/bsc_back.sv
// ----------------------------------------------------------------------------
// bsc_back
// post-division pressure correction, centidegree conversion and output register
// ----------------------------------------------------------------------------
module bsc_back
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  bsc_quo_t    quo_i,
  input  bsc_coef_t   coef_i,
  output logic        valid_o,
  output logic [31:0] cent_o,
  output logic [31:0] fine_o,
  output logic [31:0] press_o,
  output logic        inv_o
);

  logic [4:0] vld_q;
  logic signed [63:0] q, s13_d, s13_q, m1_d, m1_q, y8_d, y8_q, q1_q, q2_q, q3_q;
  logic signed [63:0] y82_q, y83_q, m2_d, m2_q, sum_d, sum_q, pf;
  logic [63:0] pll_d, pll_q;
  logic [31:0] pch_d, pch_q, pcl_d, pcl_q;
  logic [31:0] fine1_q, fine2_q, fine3_q, fine4_q, cm, cent_d, cent_q;
  logic [31:0] fine_q, press_d, press_q;
  logic inv1_q, inv2_q, inv3_q, inv4_q, inv_q;

  always_comb begin
    q       = $signed(quo_i.q);
    s13_d   = q >>> 13;
    m1_d    = 64'($signed(coef_i.p9)) * s13_d;
    y8_d    = 64'($signed(coef_i.p8)) * q;
    // low 64 bits of the wide product from 32-bit partial products
    pll_d   = {32'd0, m1_q[31:0]} * {32'd0, s13_q[31:0]};
    pch_d   = m1_q[63:32] * s13_q[31:0];
    pcl_d   = m1_q[31:0] * s13_q[63:32];
    m2_d    = $signed(pll_q + {32'(pch_q + pcl_q), 32'd0});
    sum_d   = q3_q + (m2_q >>> 25) + (y83_q >>> 19);
    pf      = (sum_q >>> 8) + (64'($signed(coef_i.p7)) <<< 4);
    press_d = inv4_q ? 32'd0 : pf[31:0];
    cm      = fine4_q * 32'd5 + 32'd128;
    cent_d  = 32'($signed(cm) >>> 8);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q1_q    <= q;       s13_q  <= s13_d;   m1_q <= m1_d;  y8_q <= y8_d;
      inv1_q  <= quo_i.inv;                  fine1_q <= quo_i.fine;
      q2_q    <= q1_q;    pll_q  <= pll_d;   pch_q <= pch_d; pcl_q <= pcl_d;
      y82_q   <= y8_q;    inv2_q <= inv1_q;  fine2_q <= fine1_q;
      q3_q    <= q2_q;    m2_q   <= m2_d;    y83_q <= y82_q;
      inv3_q  <= inv2_q;  fine3_q <= fine2_q;
      sum_q   <= sum_d;   inv4_q <= inv3_q;  fine4_q <= fine3_q;
      cent_q  <= cent_d;  fine_q <= fine4_q; press_q <= press_d;
      inv_q   <= inv4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign cent_o  = cent_q;
  assign fine_o  = fine_q;
  assign press_o = press_q;
  assign inv_o   = inv_q;

endmodule

>>> rtl/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// integer temperature and pressure compensation, fully pipelined
// ----------------------------------------------------------------------------
// channel   dir  beat
// sample_i  in   raw_temperature, raw_pressure
// result_o  out  centidegrees, fine temperature, pressure q24.8, invalid flag
// cfg_i     in   register index, 48-bit coefficient word
//
// one beat per cycle in while no result waits at the output; 10 front stages, the 64-stage
// restoring divider (one quotient bit each) and 5 back stages
// reset is asynchronous; coefficients clear to zero, no clearing pass
// a result waiting at the output freezes the whole pipeline and sample_i.ready
// ----------------------------------------------------------------------------
module barometric_sensor_compensation
  import bsc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  bsc_sample_if.sink   sample_i,
  bsc_result_if.source result_o,
  bsc_cfg_if.sink      cfg_i
);

  logic [47:0] temp_q, pa_q, pb_q, pc_q;
  bsc_coef_t coef;
  logic en, fr_valid, dv_valid, bk_valid;
  bsc_div_t fr_div;
  bsc_quo_t dv_quo;
  logic [31:0] cent, fine, press;
  logic inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      pc_q   <= '0;
    end else if (cfg_i.valid) begin
      case (bsc_reg_e'(cfg_i.index))
        BSC_REG_TEMP: temp_q <= cfg_i.data;
        BSC_REG_PA:   pa_q   <= cfg_i.data;
        BSC_REG_PB:   pb_q   <= cfg_i.data;
        BSC_REG_PC:   pc_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  assign coef = '{t1: temp_q[15:0], t2: temp_q[31:16], t3: temp_q[47:32],
                  p1: pa_q[15:0],   p2: pa_q[31:16],   p3: pa_q[47:32],
                  p4: pb_q[15:0],   p5: pb_q[31:16],   p6: pb_q[47:32],
                  p7: pc_q[15:0],   p8: pc_q[31:16],   p9: pc_q[47:32]};

  assign en             = !bk_valid || result_o.ready;
  assign sample_i.ready = en;

  bsc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sample_i.valid),
    .raw_t_i (sample_i.raw_temperature),
    .raw_p_i (sample_i.raw_pressure),
    .coef_i  (coef),
    .valid_o (fr_valid),
    .div_o   (fr_div)
  );

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .div_i   (fr_div),
    .valid_o (dv_valid),
    .quo_o   (dv_quo)
  );

  bsc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .quo_i   (dv_quo),
    .coef_i  (coef),
    .valid_o (bk_valid),
    .cent_o  (cent),
    .fine_o  (fine),
    .press_o (press),
    .inv_o   (inv)
  );

  assign result_o.valid                    = bk_valid;
  assign result_o.temperature_centidegrees = $signed(cent);
  assign result_o.fine_temperature         = $signed(fine);
  assign result_o.pressure_q24_8           = press;
  assign result_o.pressure_invalid         = inv;

endmodule

>>> rtl/bsc_checker.sv
// ----------------------------------------------------------------------------
// bsc_checker
// port-level checks on the compensation block, bound to the top level
// ----------------------------------------------------------------------------
`include "barometric_sensor_compensation_assert.svh"

module bsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] cent_i,
  input logic [31:0] fine_i,
  input logic [31:0] press_i,
  input logic        inv_i
);

  // a stalled result beat holds
  `BSC_ASSERT(a_out_hold,
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cent_i) &&
    $stable(fine_i) && $stable(press_i) && $stable(inv_i),
    "stalled result changed")
  // invalid pressure reads as zero
  `BSC_ASSERT(a_inv_zero, out_valid_i && inv_i |-> press_i == 32'd0, "invalid pressure not zero")
  // input side stalls exactly when a result waits
  `BSC_ASSERT(a_stall, in_ready_i == (!out_valid_i || out_ready_i), "input ready mismatch")
  // nothing comes out once reset has been seen
  `BSC_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_i, "result valid in reset")

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .cent_i      (result_o.temperature_centidegrees),
  .fine_i      (result_o.fine_temperature),
  .press_i     (result_o.pressure_q24_8),
  .inv_i       (result_o.pressure_invalid)
);

>>> test/tb_barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// tb_barometric_sensor_compensation
// drives raw temperature and pressure samples through the compensation
// pipeline under several coefficient sets, predicts every result in 32-bit
// and 64-bit wrapping arithmetic and checks each result beat in order
// ----------------------------------------------------------------------------
module tb_barometric_sensor_compensation;
  import bsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] cent;
    logic [31:0] fine;
    logic [31:0] press;
    logic        inv;
  } comp_result_t;

  class comp_scoreboard;
    logic [47:0]  coef[4];
    comp_result_t pending_q[$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  invalid_seen;

    function new();
      for (int i = 0; i < 4; i++) coef[i] = '0;
      mismatches = 0;
      checked = 0;
      invalid_seen = 0;
    endfunction

    function logic [63:0] asr(logic [63:0] v, int s);
      return $signed(v) >>> s;
    endfunction

    function logic [63:0] sx16(logic [15:0] w);
      return {{48{w[15]}}, w};
    endfunction

    function logic [63:0] sdiv(logic [63:0] n, logic [63:0] d);
      logic [63:0] mn, md, q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q = mn / md;
      return (n[63] != d[63]) ? -q : q;
    endfunction

    function void note_sample(logic [19:0] rt, logic [19:0] rp);
      logic [31:0] adc_t, t1, t2, t3, a, b, fine, cent;
      logic [63:0] adc_p, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] x, y, den, p, n;
      comp_result_t r;
      adc_t = {12'd0, rt};
      adc_p = {44'd0, rp};
      t1 = {16'd0, coef[BSC_REG_TEMP][15:0]};
      t2 = 32'(sx16(coef[BSC_REG_TEMP][31:16]));
      t3 = 32'(sx16(coef[BSC_REG_TEMP][47:32]));
      p1 = {48'd0, coef[BSC_REG_PA][15:0]};
      p2 = sx16(coef[BSC_REG_PA][31:16]);
      p3 = sx16(coef[BSC_REG_PA][47:32]);
      p4 = sx16(coef[BSC_REG_PB][15:0]);
      p5 = sx16(coef[BSC_REG_PB][31:16]);
      p6 = sx16(coef[BSC_REG_PB][47:32]);
      p7 = sx16(coef[BSC_REG_PC][15:0]);
      p8 = sx16(coef[BSC_REG_PC][31:16]);
      p9 = sx16(coef[BSC_REG_PC][47:32]);
      a = ((adc_t >> 3) - (t1 << 1)) * t2;
      a = $signed(a) >>> 11;
      b = (adc_t >> 4) - t1;
      b = b * b;
      b = $signed(b) >>> 12;
      b = b * t3;
      b = $signed(b) >>> 14;
      fine = a + b;
      cent = fine * 32'd5 + 32'd128;
      cent = $signed(cent) >>> 8;
      x = {{32{fine[31]}}, fine} - 64'd128000;
      y = x * x * p6;
      y = y + ((x * p5) << 17);
      y = y + (p4 << 35);
      n = x * x * p3;
      x = asr(n, 8) + ((x * p2) << 12);
      den = ((64'd1 << 47) + x) * p1;
      den = asr(den, 33);
      r.cent = cent;
      r.fine = fine;
      r.press = '0;
      r.inv = 1'b0;
      if (den == 64'd0) begin
        r.inv = 1'b1;
      end else begin
        p = 64'd1048576 - adc_p;
        n = ((p << 31) - y) * 64'd3125;
        p = sdiv(n, den);
        x = p9 * asr(p, 13);
        x = x * asr(p, 13);
        x = asr(x, 25);
        y = asr(p8 * p, 19);
        p = asr(p + x + y, 8) + (p7 << 4);
        r.press = p[31:0];
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(comp_result_t got);
      comp_result_t exp_r;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r.inv) invalid_seen++;
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: cent %h/%h fine %h/%h press %h/%h inv %b/%b (exp/act)",
                   exp_r.cent, got.cent, exp_r.fine, got.fine,
                   exp_r.press, got.press, exp_r.inv, got.inv);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bsc_sample_if sample_if ();
  bsc_result_if result_if ();
  bsc_cfg_if    cfg_if ();

  barometric_sensor_compensation DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  comp_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned samples_sent = 0;
  int unsigned stall_period = 1;
  int unsigned stall_duty = 1;
  int unsigned stall_cnt = 0;
  int unsigned stall_phase = 0;

  initial begin
    sample_if.valid = 1'b0;
    sample_if.raw_temperature = '0;
    sample_if.raw_pressure = '0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = BSC_REG_TEMP;
    cfg_if.data = '0;
  end

  // receiver ready pattern: ready is high while the phase is below duty in each period
  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 300 == 0) begin
      stall_period <= $urandom_range(1, 12);
      stall_duty <= $urandom_range(1, 12);
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1 >= stall_period) ? 0 : stall_phase + 1;
    end
    result_if.ready <= (stall_phase < stall_duty);
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready)
      sb.check_result({result_if.temperature_centidegrees, result_if.fine_temperature,
                       result_if.pressure_q24_8, result_if.pressure_invalid});
  end

  task automatic send_sample(logic [19:0] rt, logic [19:0] rp);
    if (burst_left == 0) begin
      sample_if.valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 40);
    end
    sample_if.valid <= 1'b1;
    sample_if.raw_temperature <= rt;
    sample_if.raw_pressure <= rp;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    sb.note_sample(rt, rp);
    samples_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic write_coefs(logic [47:0] c0, logic [47:0] c1, logic [47:0] c2,
                             logic [47:0] c3);
    logic [47:0] vals[4];
    vals = '{c0, c1, c2, c3};
    for (int i = 0; i < 4; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= bsc_reg_e'(i);
      cfg_if.data <= vals[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      sb.coef[i] = vals[i];
      @(negedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    sample_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(0, 5))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  initial begin
    logic [47:0] typical[4];
    int unsigned phases;
    phases = 0;
    typical[0] = {16'hFC18, 16'd26435, 16'd27504};
    typical[1] = {16'd3024, 16'hD643, 16'd36477};
    typical[2] = {16'hFFF9, 16'd140, 16'd2855};
    typical[3] = {16'd6000, 16'hC6F8, 16'd15500};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    // reset coefficients are zero: divisor is zero
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();

    write_coefs(typical[0], typical[1], typical[2], typical[3]);
    phases++;
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h80000, 20'h80000);
    send_sample(20'h7FFFF, 20'h7FFFF);
    send_sample(20'hAAAAA, 20'h55555);
    send_sample(20'h55555, 20'hAAAAA);
    for (int i = 0; i < 150; i++) send_sample(20'($urandom), 20'($urandom));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_coefs('0, '0, '0, '0);
        1: write_coefs('1, '1, '1, '1);
        2: write_coefs({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        3: write_coefs({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        4: write_coefs(typical[0], {typical[1][47:16], 16'd0}, typical[2], typical[3]);
        default: write_coefs(rand48(), rand48(), rand48(), rand48());
      endcase
      phases++;
      for (int i = 0; i < 75; i++) send_sample(rand_raw(), rand_raw());
      drain();
    end

    if (sb.mismatches != 0 || sb.pending_q.size() != 0) begin
      $display("ran %0d samples over %0d coefficient sets, %0d results, %0d invalid",
               samples_sent, phases, sb.checked, sb.invalid_seen);
      $display("tb: failure");
    end else begin
      $display("ran %0d samples over %0d coefficient sets, %0d results, %0d invalid",
               samples_sent, phases, sb.checked, sb.invalid_seen);
      $display("tb: success");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end
endmodule
